// ----- rtl/rlns_pkg.sv -----
package rlns_pkg;

  localparam int unsigned DEF_MAX_COMPONENTS   = 1024;
  localparam int unsigned DEF_MAX_RELAY_PIXELS = 1024;
  localparam int unsigned DEF_MAX_ADJ_ENTRIES  = 4096;
  localparam int unsigned DEF_MAX_DRIVERS      = 1024;
  localparam int unsigned DEF_MAX_RELAYS       = 1024;
  localparam int unsigned DEF_MAX_INPUTS       = 4;

  localparam int COUNT_W = 11;
  localparam int RANGE_W = 24;
  localparam int ADJ_W   = 10;

  localparam logic [3:0] OP_RANGE  = 4'd0;
  localparam logic [3:0] OP_ADJ    = 4'd1;
  localparam logic [3:0] OP_PIXNB  = 4'd2;
  localparam logic [3:0] OP_DRIVER = 4'd3;
  localparam logic [3:0] OP_RELAY  = 4'd4;
  localparam logic [3:0] OP_WRLVL  = 4'd5;
  localparam logic [3:0] OP_STEP   = 4'd6;
  localparam logic [3:0] OP_SETTLE = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;

  localparam logic [2:0] DRV_SOURCE = 3'd0;
  localparam logic [2:0] DRV_AND    = 3'd1;
  localparam logic [2:0] DRV_OR     = 3'd2;
  localparam logic [2:0] DRV_NAND   = 3'd3;
  localparam logic [2:0] DRV_NOR    = 3'd4;

  localparam logic [2:0] REL_POS = 3'd0;
  localparam logic [2:0] REL_NEG = 3'd1;

  localparam logic [2:0] LVL_COMP = 3'd0;
  localparam logic [2:0] LVL_PIX  = 3'd1;
  localparam logic [2:0] LVL_COND = 3'd2;

  localparam logic [1:0] REG_COMP = 2'd0;
  localparam logic [1:0] REG_PIX  = 2'd1;
  localparam logic [1:0] REG_DRV  = 2'd2;
  localparam logic [1:0] REG_RLY  = 2'd3;

  localparam logic [1:0] RSEL_NONE = 2'd0;
  localparam logic [1:0] RSEL_COMP = 2'd1;
  localparam logic [1:0] RSEL_PIX  = 2'd2;
  localparam logic [1:0] RSEL_COND = 2'd3;

  typedef logic [4:0] state_t;

  localparam state_t S_INIT    = 5'd0;
  localparam state_t S_IDLE    = 5'd1;
  localparam state_t S_DECODE  = 5'd2;
  localparam state_t S_RDWAIT  = 5'd3;
  localparam state_t S_CLR     = 5'd4;
  localparam state_t S_G_RD    = 5'd5;
  localparam state_t S_G_ENT   = 5'd6;
  localparam state_t S_G_LNK   = 5'd7;
  localparam state_t S_G_LDAT  = 5'd8;
  localparam state_t S_G_APPLY = 5'd9;
  localparam state_t S_COPY_R  = 5'd10;
  localparam state_t S_COPY_W  = 5'd11;
  localparam state_t S_FINIT   = 5'd12;
  localparam state_t S_FINIT_D = 5'd13;
  localparam state_t S_POP     = 5'd14;
  localparam state_t S_POP_D   = 5'd15;
  localparam state_t S_P_ENT   = 5'd16;
  localparam state_t S_P_LNK   = 5'd17;
  localparam state_t S_P_LDAT  = 5'd18;
  localparam state_t S_C_ENT   = 5'd19;
  localparam state_t S_C_LNK   = 5'd20;
  localparam state_t S_C_ADAT  = 5'd21;
  localparam state_t S_C_PDAT  = 5'd22;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  count;
    logic [11:0] link_a;
    logic [11:0] link_b;
    logic [9:0]  link_c;
    logic [9:0]  link_d;
    logic [9:0]  target;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0] op;
    logic       clr_last;
    logic       gate_more;
    logic       mode_rly;
    logic       link_more;
    logic       link_ok;
    logic       copy_last;
    logic       init_more;
    logic       stack_empty;
    logic       elem_pix;
    logic       adj_more;
    logic       pix_ok;
  } dp_status_t;

  function automatic int addr_w(int d);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [31:0] sat_count(logic [COUNT_W-1:0] v, int unsigned m);
    return (32'(v) < m) ? 32'(v) : 32'(m);
  endfunction

  function automatic logic gate_level(logic [2:0] kind, logic [2:0] hi, logic [2:0] cnt);
    logic v;
    unique case (kind)
      DRV_SOURCE: v = 1'b1;
      DRV_AND:    v = (hi == cnt);
      DRV_OR:     v = (hi != 3'd0);
      DRV_NAND:   v = (hi != cnt);
      DRV_NOR:    v = (hi == 3'd0);
      default:    v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/rlns_ram.sv -----
module rlns_ram #(
  parameter int W = 1,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rlns_ctrl.sv -----
module rlns_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  rlns_pkg::dp_status_t   status,
  output rlns_pkg::state_t       cmd,
  output logic                   busy
);
  import rlns_pkg::*;

  state_t state_r, state_nxt;

  assign cmd  = state_r;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:    if (status.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        if (status.op == OP_STEP) state_nxt = S_CLR;
        else if (status.op == OP_SETTLE) state_nxt = S_FINIT;
        else if (status.op == OP_READ) state_nxt = S_RDWAIT;
        else state_nxt = S_IDLE;
      end
      S_RDWAIT:  state_nxt = S_IDLE;
      S_CLR:     if (status.clr_last) state_nxt = S_G_RD;
      S_G_RD: begin
        if (status.gate_more) state_nxt = S_G_ENT;
        else if (status.mode_rly) state_nxt = S_COPY_R;
      end
      S_G_ENT:   state_nxt = S_G_LNK;
      S_G_LNK: begin
        if (!status.link_more) state_nxt = S_G_APPLY;
        else if (status.link_ok) state_nxt = S_G_LDAT;
      end
      S_G_LDAT:  state_nxt = S_G_LNK;
      S_G_APPLY: state_nxt = S_G_RD;
      S_COPY_R:  state_nxt = S_COPY_W;
      S_COPY_W:  state_nxt = status.copy_last ? S_FINIT : S_COPY_R;
      S_FINIT:   state_nxt = status.init_more ? S_FINIT_D : S_POP;
      S_FINIT_D: state_nxt = S_FINIT;
      S_POP:     state_nxt = status.stack_empty ? S_IDLE : S_POP_D;
      S_POP_D:   state_nxt = status.elem_pix ? S_P_ENT : S_C_ENT;
      S_P_ENT:   state_nxt = S_P_LNK;
      S_P_LNK: begin
        if (!status.link_more) state_nxt = S_POP;
        else if (status.link_ok) state_nxt = S_P_LDAT;
      end
      S_P_LDAT:  state_nxt = S_P_LNK;
      S_C_ENT:   state_nxt = S_C_LNK;
      S_C_LNK:   state_nxt = status.adj_more ? S_C_ADAT : S_POP;
      S_C_ADAT:  state_nxt = status.pix_ok ? S_C_PDAT : S_C_LNK;
      S_C_PDAT:  state_nxt = S_C_LNK;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/rlns_dpath.sv -----
module rlns_dpath #(
  parameter int unsigned MAX_COMPONENTS   = rlns_pkg::DEF_MAX_COMPONENTS,
  parameter int unsigned MAX_RELAY_PIXELS = rlns_pkg::DEF_MAX_RELAY_PIXELS,
  parameter int unsigned MAX_ADJ_ENTRIES  = rlns_pkg::DEF_MAX_ADJ_ENTRIES,
  parameter int unsigned MAX_DRIVERS      = rlns_pkg::DEF_MAX_DRIVERS,
  parameter int unsigned MAX_RELAYS       = rlns_pkg::DEF_MAX_RELAYS,
  parameter int unsigned MAX_INPUTS       = rlns_pkg::DEF_MAX_INPUTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlns_pkg::state_t     cmd,
  input  logic                 start,
  input  logic [3:0]           in_op,
  input  logic [11:0]          in_slot,
  input  logic [2:0]           in_kind,
  input  logic [2:0]           in_input_count,
  input  logic [11:0]          in_link_a,
  input  logic [11:0]          in_link_b,
  input  logic [9:0]           in_link_c,
  input  logic [9:0]           in_link_d,
  input  logic [9:0]           in_target,
  input  logic                 in_level,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  output rlns_pkg::dp_status_t status,
  output logic                 out_valid,
  output logic                 out_read_level,
  output logic                 out_step_done
);
  import rlns_pkg::*;

  localparam int AWC = addr_w(MAX_COMPONENTS);
  localparam int AWP = addr_w(MAX_RELAY_PIXELS);
  localparam int AWA = addr_w(MAX_ADJ_ENTRIES);
  localparam int AWD = addr_w(MAX_DRIVERS);
  localparam int AWR = addr_w(MAX_RELAYS);
  localparam int unsigned STACK_DEPTH = MAX_COMPONENTS + MAX_RELAY_PIXELS;
  localparam int AWS = addr_w(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int EIW = max2(AWC, AWP);
  localparam int EW  = EIW + 1;
  localparam int unsigned CLR_N = max2(MAX_COMPONENTS, MAX_RELAY_PIXELS);
  localparam int unsigned MAX_ALL = max2(max2(max2(CLR_N, MAX_ADJ_ENTRIES),
                                              MAX_DRIVERS), MAX_RELAYS);
  localparam int XW = max2(13, $clog2(MAX_ALL + 1));

  logic [10:0]     comp_count_r, pix_count_r, drv_count_r, rly_count_r;
  logic [3:0]      op_r;
  logic [11:0]     slot_r;
  logic            level_r;
  entry_t          item_r;
  entry_t          ent_r;
  logic [2:0]      k_r, hi_r;
  logic [XW-1:0]   idx_r;
  logic [11:0]     end_r;
  logic [11:0]     c_r;
  logic [ADJ_W-1:0] p_r;
  logic [SPW-1:0]  sp_r;
  logic            mode_r;
  logic [1:0]      rsel_r;
  logic            out_valid_r, read_level_r, step_done_r;

  logic [31:0]     nc, np, nd, nr;
  logic [2:0]      cnt_sat;
  logic [11:0]     cur_link;
  logic            lvl_comp, lvl_pix, lvl_cond;
  logic            rly_val;

  logic comp_we, next_we, cond_we, pix_we, range_we, adj_we, pixnb_we, drv_we, rly_we;
  logic [AWC-1:0] comp_waddr, comp_raddr, next_waddr, next_raddr, range_waddr, range_raddr;
  logic [AWP-1:0] cond_waddr, cond_raddr, pix_waddr, pix_raddr, pixnb_waddr, pixnb_raddr;
  logic [AWA-1:0] adj_waddr, adj_raddr;
  logic [AWD-1:0] drv_waddr, drv_raddr;
  logic [AWR-1:0] rly_waddr, rly_raddr;
  logic comp_wdata, next_wdata, cond_wdata, pix_wdata;
  logic comp_rdata, next_rdata, cond_rdata, pix_rdata;
  logic [RANGE_W-1:0] range_rdata;
  logic [ADJ_W-1:0]   adj_rdata;
  logic [ENT_W-1:0]   pixnb_rdata, drv_rdata, rly_rdata;
  logic               push_en, stack_we;
  logic [EW-1:0]      push_data, stack_rdata;
  logic [AWS-1:0]     stack_waddr, stack_raddr;

  assign nc = sat_count(comp_count_r, MAX_COMPONENTS);
  assign np = sat_count(pix_count_r, MAX_RELAY_PIXELS);
  assign nd = sat_count(drv_count_r, MAX_DRIVERS);
  assign nr = sat_count(rly_count_r, MAX_RELAYS);

  assign cnt_sat = (32'(ent_r.count) > MAX_INPUTS) ? 3'(MAX_INPUTS) : ent_r.count;

  always_comb begin
    unique case (k_r)
      3'd0:    cur_link = ent_r.link_a;
      3'd1:    cur_link = ent_r.link_b;
      3'd2:    cur_link = {2'b00, ent_r.link_c};
      3'd3:    cur_link = {2'b00, ent_r.link_d};
      default: cur_link = 12'd0;
    endcase
  end

  assign lvl_comp = (item_r.kind == LVL_COMP) && (32'(slot_r) < MAX_COMPONENTS);
  assign lvl_pix  = (item_r.kind == LVL_PIX)  && (32'(slot_r) < MAX_RELAY_PIXELS);
  assign lvl_cond = (item_r.kind == LVL_COND) && (32'(slot_r) < MAX_RELAY_PIXELS);
  assign rly_val  = (ent_r.kind == REL_POS) ? (hi_r != 3'd0) : (hi_r != cnt_sat);

  assign status.op          = op_r;
  assign status.clr_last    = (32'(idx_r) == CLR_N - 1);
  assign status.gate_more   = 32'(idx_r) < (mode_r ? nr : nd);
  assign status.mode_rly    = mode_r;
  assign status.link_more   = (k_r < cnt_sat);
  assign status.link_ok     = (32'(cur_link) < nc);
  assign status.copy_last   = (32'(idx_r) == MAX_COMPONENTS - 1);
  assign status.init_more   = (32'(idx_r) < nc);
  assign status.stack_empty = (sp_r == '0);
  assign status.elem_pix    = stack_rdata[0];
  assign status.adj_more    = (32'(idx_r) < 32'(end_r)) && (32'(idx_r) < MAX_ADJ_ENTRIES);
  assign status.pix_ok      = (32'(adj_rdata) < np);

  always_comb begin
    push_en   = 1'b0;
    push_data = {EIW'(idx_r), 1'b0};
    unique case (cmd)
      S_FINIT_D: push_en = comp_rdata;
      S_P_LDAT: begin
        push_en   = !comp_rdata;
        push_data = {EIW'(c_r), 1'b0};
      end
      S_C_PDAT: begin
        push_en   = cond_rdata && !pix_rdata;
        push_data = {EIW'(p_r), 1'b1};
      end
      default: push_en = 1'b0;
    endcase
  end

  assign stack_we    = push_en && (32'(sp_r) < STACK_DEPTH);
  assign stack_waddr = AWS'(sp_r);
  assign stack_raddr = AWS'(sp_r - SPW'(1));

  always_comb begin
    comp_we = 1'b0; next_we = 1'b0; cond_we = 1'b0; pix_we = 1'b0;
    range_we = 1'b0; adj_we = 1'b0; pixnb_we = 1'b0; drv_we = 1'b0; rly_we = 1'b0;
    comp_waddr = AWC'(idx_r); comp_wdata = 1'b0;
    next_waddr = AWC'(idx_r); next_wdata = 1'b0;
    cond_waddr = AWP'(idx_r); cond_wdata = 1'b0;
    pix_waddr  = AWP'(idx_r); pix_wdata  = 1'b0;
    range_waddr = AWC'(slot_r);
    adj_waddr   = AWA'(slot_r);
    pixnb_waddr = AWP'(slot_r);
    drv_waddr   = AWD'(slot_r);
    rly_waddr   = AWR'(slot_r);
    unique case (cmd)
      S_INIT, S_CLR: begin
        comp_we = (cmd == S_INIT) && (32'(idx_r) < MAX_COMPONENTS);
        next_we = (32'(idx_r) < MAX_COMPONENTS);
        cond_we = (32'(idx_r) < MAX_RELAY_PIXELS);
        pix_we  = (32'(idx_r) < MAX_RELAY_PIXELS);
      end
      S_DECODE: begin
        unique case (op_r)
          OP_RANGE:  range_we = (32'(slot_r) < MAX_COMPONENTS);
          OP_ADJ:    adj_we   = (32'(slot_r) < MAX_ADJ_ENTRIES);
          OP_PIXNB:  pixnb_we = (32'(slot_r) < MAX_RELAY_PIXELS);
          OP_DRIVER: drv_we   = (32'(slot_r) < MAX_DRIVERS);
          OP_RELAY:  rly_we   = (32'(slot_r) < MAX_RELAYS);
          OP_WRLVL: begin
            comp_we = lvl_comp; comp_waddr = AWC'(slot_r); comp_wdata = level_r;
            pix_we  = lvl_pix;  pix_waddr  = AWP'(slot_r); pix_wdata  = level_r;
            cond_we = lvl_cond; cond_waddr = AWP'(slot_r); cond_wdata = level_r;
          end
          default: comp_we = 1'b0;
        endcase
      end
      S_G_APPLY: begin
        if (!mode_r) begin
          next_we    = gate_level(ent_r.kind, hi_r, cnt_sat) && (32'(ent_r.target) < nc);
          next_waddr = AWC'(ent_r.target);
          next_wdata = 1'b1;
        end else begin
          cond_we    = (ent_r.kind <= REL_NEG) && (32'(ent_r.target) < np);
          cond_waddr = AWP'(ent_r.target);
          cond_wdata = rly_val;
        end
      end
      S_COPY_W: begin
        comp_we    = 1'b1;
        comp_wdata = next_rdata;
      end
      S_P_LDAT: begin
        comp_we    = !comp_rdata;
        comp_waddr = AWC'(c_r);
        comp_wdata = 1'b1;
      end
      S_C_PDAT: begin
        pix_we    = cond_rdata && !pix_rdata;
        pix_waddr = AWP'(p_r);
        pix_wdata = 1'b1;
      end
      default: comp_we = 1'b0;
    endcase
  end

  always_comb begin
    comp_raddr = AWC'(slot_r);
    cond_raddr = AWP'(slot_r);
    pix_raddr  = AWP'(slot_r);
    unique case (cmd)
      S_G_LNK, S_P_LNK: comp_raddr = AWC'(cur_link);
      S_FINIT:          comp_raddr = AWC'(idx_r);
      S_C_ADAT: begin
        cond_raddr = AWP'(adj_rdata);
        pix_raddr  = AWP'(adj_rdata);
      end
      default: comp_raddr = AWC'(slot_r);
    endcase
  end

  assign next_raddr  = AWC'(idx_r);
  assign adj_raddr   = AWA'(idx_r);
  assign drv_raddr   = AWD'(idx_r);
  assign rly_raddr   = AWR'(idx_r);
  assign range_raddr = AWC'(stack_rdata[EW-1:1]);
  assign pixnb_raddr = AWP'(stack_rdata[EW-1:1]);

  rlns_ram #(.W(1), .D(MAX_COMPONENTS)) u_comp (
    .clk(clk), .we(comp_we), .waddr(comp_waddr), .wdata(comp_wdata),
    .raddr(comp_raddr), .rdata(comp_rdata));
  rlns_ram #(.W(1), .D(MAX_COMPONENTS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(next_rdata));
  rlns_ram #(.W(1), .D(MAX_RELAY_PIXELS)) u_cond (
    .clk(clk), .we(cond_we), .waddr(cond_waddr), .wdata(cond_wdata),
    .raddr(cond_raddr), .rdata(cond_rdata));
  rlns_ram #(.W(1), .D(MAX_RELAY_PIXELS)) u_pix (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .raddr(pix_raddr), .rdata(pix_rdata));
  rlns_ram #(.W(RANGE_W), .D(MAX_COMPONENTS)) u_range (
    .clk(clk), .we(range_we), .waddr(range_waddr), .wdata({item_r.link_a, item_r.link_b}),
    .raddr(range_raddr), .rdata(range_rdata));
  rlns_ram #(.W(ADJ_W), .D(MAX_ADJ_ENTRIES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(item_r.target),
    .raddr(adj_raddr), .rdata(adj_rdata));
  rlns_ram #(.W(ENT_W), .D(MAX_RELAY_PIXELS)) u_pixnb (
    .clk(clk), .we(pixnb_we), .waddr(pixnb_waddr), .wdata(item_r),
    .raddr(pixnb_raddr), .rdata(pixnb_rdata));
  rlns_ram #(.W(ENT_W), .D(MAX_DRIVERS)) u_drv (
    .clk(clk), .we(drv_we), .waddr(drv_waddr), .wdata(item_r),
    .raddr(drv_raddr), .rdata(drv_rdata));
  rlns_ram #(.W(ENT_W), .D(MAX_RELAYS)) u_rly (
    .clk(clk), .we(rly_we), .waddr(rly_waddr), .wdata(item_r),
    .raddr(rly_raddr), .rdata(rly_rdata));
  rlns_ram #(.W(EW), .D(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(push_data),
    .raddr(stack_raddr), .rdata(stack_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_count_r <= '0;
      pix_count_r  <= '0;
      drv_count_r  <= '0;
      rly_count_r  <= '0;
      idx_r        <= '0;
      sp_r         <= '0;
      mode_r       <= 1'b0;
      rsel_r       <= RSEL_NONE;
      out_valid_r  <= 1'b0;
      read_level_r <= 1'b0;
      step_done_r  <= 1'b0;
    end else begin
      out_valid_r  <= 1'b0;
      read_level_r <= 1'b0;
      step_done_r  <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COMP: comp_count_r <= cfg_data;
          REG_PIX:  pix_count_r  <= cfg_data;
          REG_DRV:  drv_count_r  <= cfg_data;
          REG_RLY:  rly_count_r  <= cfg_data;
          default:  rly_count_r  <= rly_count_r;
        endcase
      end
      if (stack_we || (push_en && (32'(sp_r) < STACK_DEPTH))) begin
        sp_r <= sp_r + SPW'(1);
      end
      unique case (cmd)
        S_INIT, S_CLR: begin
          idx_r  <= status.clr_last ? '0 : idx_r + XW'(1);
          mode_r <= 1'b0;
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= in_op;
            slot_r  <= in_slot;
            level_r <= in_level;
            item_r  <= '{kind: in_kind, count: in_input_count, link_a: in_link_a,
                         link_b: in_link_b, link_c: in_link_c, link_d: in_link_d,
                         target: in_target};
          end
        end
        S_DECODE: begin
          idx_r  <= '0;
          sp_r   <= '0;
          mode_r <= 1'b0;
          if (op_r == OP_READ) begin
            if (lvl_comp) rsel_r <= RSEL_COMP;
            else if (lvl_pix) rsel_r <= RSEL_PIX;
            else if (lvl_cond) rsel_r <= RSEL_COND;
            else rsel_r <= RSEL_NONE;
          end else if (op_r != OP_STEP && op_r != OP_SETTLE) begin
            out_valid_r <= 1'b1;
          end
        end
        S_RDWAIT: begin
          out_valid_r <= 1'b1;
          unique case (rsel_r)
            RSEL_COMP: read_level_r <= comp_rdata;
            RSEL_PIX:  read_level_r <= pix_rdata;
            RSEL_COND: read_level_r <= cond_rdata;
            default:   read_level_r <= 1'b0;
          endcase
        end
        S_G_RD: begin
          if (!status.gate_more && !mode_r) begin
            mode_r <= 1'b1;
            idx_r  <= '0;
          end else if (!status.gate_more) begin
            idx_r  <= '0;
          end
        end
        S_G_ENT: begin
          ent_r <= mode_r ? entry_t'(rly_rdata) : entry_t'(drv_rdata);
          k_r   <= '0;
          hi_r  <= '0;
        end
        S_G_LNK, S_P_LNK: begin
          c_r <= cur_link;
          if (status.link_more && !status.link_ok) k_r <= k_r + 3'd1;
        end
        S_G_LDAT: begin
          if (comp_rdata) hi_r <= hi_r + 3'd1;
          k_r <= k_r + 3'd1;
        end
        S_G_APPLY: idx_r <= idx_r + XW'(1);
        S_COPY_W:  idx_r <= status.copy_last ? '0 : idx_r + XW'(1);
        S_FINIT_D: idx_r <= idx_r + XW'(1);
        S_POP: begin
          if (status.stack_empty) begin
            out_valid_r <= 1'b1;
            step_done_r <= 1'b1;
          end else begin
            sp_r <= sp_r - SPW'(1);
          end
        end
        S_P_ENT: begin
          ent_r <= entry_t'(pixnb_rdata);
          k_r   <= '0;
        end
        S_P_LDAT: k_r <= k_r + 3'd1;
        S_C_ENT: begin
          idx_r <= XW'(range_rdata[RANGE_W-1:12]);
          end_r <= range_rdata[11:0];
        end
        S_C_ADAT: begin
          p_r <= adj_rdata;
          if (!status.pix_ok) idx_r <= idx_r + XW'(1);
        end
        S_C_PDAT: idx_r <= idx_r + XW'(1);
        default: mode_r <= mode_r;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_level = read_level_r;
  assign out_step_done  = step_done_r;

endmodule

// ----- rtl/relay_logic_netlist_step.sv -----
// Relay logic netlist stepper.
// Command channel: drive the in_ fields with start; an item is taken on a
// clock edge where start is high and busy is low. Table loads (component
// ranges, adjacency entries, relay pixel neighbors, drivers, relays), level
// writes and unknown ops are applied in the decode state; a read fetches its
// level in a wait state after decode. Busy stays high until each result.
// Every item gives one result: out_valid is high for one cycle with
// out_read_level (read op) and out_step_done (step and settle ops).
// A step clears the scratch levels, evaluates each driver and relay from
// the levels of its inputs below the component count, copies the new
// levels of all MAX_COMPONENTS components, then floods. The flood scans each
// component in use and pushes the high ones, then pops the stack: a pixel
// element visits its neighbors below the component count, and a component
// element its adjacency entries, pushing each conducting pixel in use that
// is newly reached.
// Counts are written on the cfg_ channel (valid/ready, always ready); write
// them only while the block is idle, which the block itself does not enforce.
// After reset the level memories are cleared, one entry a cycle, over
// max(MAX_COMPONENTS, MAX_RELAY_PIXELS) entries with busy high.
// Results cannot be held off by the receiver.
module relay_logic_netlist_step #(
  parameter int unsigned MAX_COMPONENTS   = rlns_pkg::DEF_MAX_COMPONENTS,
  parameter int unsigned MAX_RELAY_PIXELS = rlns_pkg::DEF_MAX_RELAY_PIXELS,
  parameter int unsigned MAX_ADJ_ENTRIES  = rlns_pkg::DEF_MAX_ADJ_ENTRIES,
  parameter int unsigned MAX_DRIVERS      = rlns_pkg::DEF_MAX_DRIVERS,
  parameter int unsigned MAX_RELAYS       = rlns_pkg::DEF_MAX_RELAYS,
  parameter int unsigned MAX_INPUTS       = rlns_pkg::DEF_MAX_INPUTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_op,
  input  logic [11:0] in_slot,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_input_count,
  input  logic [11:0] in_link_a,
  input  logic [11:0] in_link_b,
  input  logic [9:0]  in_link_c,
  input  logic [9:0]  in_link_d,
  input  logic [9:0]  in_target,
  input  logic        in_level,
  output logic        out_valid,
  output logic        out_read_level,
  output logic        out_step_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import rlns_pkg::*;

  state_t     cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rlns_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .status(status), .cmd(cmd), .busy(busy));

  rlns_dpath #(
    .MAX_COMPONENTS(MAX_COMPONENTS), .MAX_RELAY_PIXELS(MAX_RELAY_PIXELS),
    .MAX_ADJ_ENTRIES(MAX_ADJ_ENTRIES), .MAX_DRIVERS(MAX_DRIVERS),
    .MAX_RELAYS(MAX_RELAYS), .MAX_INPUTS(MAX_INPUTS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .start(start),
    .in_op(in_op), .in_slot(in_slot), .in_kind(in_kind),
    .in_input_count(in_input_count), .in_link_a(in_link_a), .in_link_b(in_link_b),
    .in_link_c(in_link_c), .in_link_d(in_link_d), .in_target(in_target),
    .in_level(in_level), .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .status(status), .out_valid(out_valid),
    .out_read_level(out_read_level), .out_step_done(out_step_done));

  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

  a_done_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_step_done || out_read_level) |-> out_valid)
    else $error("result field set outside a result cycle");

  a_read_not_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_step_done |-> !out_read_level)
    else $error("step result carries a read level");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

endmodule

// ----- sim/relay_logic_netlist_step_checker.sv -----
module relay_logic_netlist_step_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [3:0]  in_op,
  input  logic [11:0] in_slot,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_input_count,
  input  logic [11:0] in_link_a,
  input  logic [11:0] in_link_b,
  input  logic [9:0]  in_link_c,
  input  logic [9:0]  in_link_d,
  input  logic [9:0]  in_target,
  input  logic        in_level,
  input  logic        out_valid,
  input  logic        out_read_level,
  input  logic        out_step_done,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          pending,
  output int          errors
);
  import rlns_pkg::*;

  localparam int NCOMP = DEF_MAX_COMPONENTS;
  localparam int NPIX  = DEF_MAX_RELAY_PIXELS;
  localparam int NADJ  = DEF_MAX_ADJ_ENTRIES;
  localparam int NDRV  = DEF_MAX_DRIVERS;
  localparam int NRLY  = DEF_MAX_RELAYS;
  localparam int NIN   = DEF_MAX_INPUTS;

  typedef struct packed {
    logic rd;
    logic done;
  } level_result_t;

  logic [10:0]   comp_n, pix_n, drv_n, rly_n;
  logic          comp_lv [NCOMP];
  logic          next_lv [NCOMP];
  logic          cond    [NPIX];
  logic          pix_lv  [NPIX];
  logic [11:0]   rng_beg [NCOMP];
  logic [11:0]   rng_end [NCOMP];
  logic [9:0]    adj     [NADJ];
  entry_t        pix_nb  [NPIX];
  entry_t        drv_tab [NDRV];
  entry_t        rly_tab [NRLY];
  level_result_t level_q [$];

  assign pending = level_q.size();

  function automatic int clip(int v, int m);
    return (v < m) ? v : m;
  endfunction

  function automatic int link_of(entry_t e, int k);
    case (k)
      0: return int'(e.link_a);
      1: return int'(e.link_b);
      2: return int'(e.link_c);
      default: return int'(e.link_d);
    endcase
  endfunction

  function automatic int high_inputs(entry_t e, output int cnt);
    int nc, hi, c;
    nc = clip(comp_n, NCOMP);
    hi = 0;
    cnt = clip(e.count, NIN);
    for (int k = 0; k < cnt; k++) begin
      c = link_of(e, k);
      if (c < nc && comp_lv[c]) hi++;
    end
    return hi;
  endfunction

  function automatic void flood_levels();
    int stk [$];
    int nc, np, e, idx, c, p, cnt;
    nc = clip(comp_n, NCOMP);
    np = clip(pix_n, NPIX);
    for (int i = 0; i < nc; i++)
      if (comp_lv[i]) stk.push_back(i * 2);
    while (stk.size() > 0) begin
      e = stk.pop_back();
      idx = e >> 1;
      if (e & 1) begin
        if (idx < NPIX) begin
          cnt = clip(pix_nb[idx].count, NIN);
          for (int k = 0; k < cnt; k++) begin
            c = link_of(pix_nb[idx], k);
            if (c < nc && !comp_lv[c]) begin
              comp_lv[c] = 1'b1;
              stk.push_back(c * 2);
            end
          end
        end
      end else if (idx < NCOMP) begin
        for (int j = rng_beg[idx]; j < rng_end[idx] && j < NADJ; j++) begin
          p = adj[j];
          if (p < np && cond[p] && !pix_lv[p]) begin
            pix_lv[p] = 1'b1;
            stk.push_back(p * 2 + 1);
          end
        end
      end
    end
  endfunction

  function automatic void step_levels();
    int nc, np, nd, nr, hi, cnt;
    logic v;
    nc = clip(comp_n, NCOMP);
    np = clip(pix_n, NPIX);
    nd = clip(drv_n, NDRV);
    nr = clip(rly_n, NRLY);
    foreach (next_lv[i]) next_lv[i] = 1'b0;
    for (int i = 0; i < nd; i++) begin
      hi = high_inputs(drv_tab[i], cnt);
      case (drv_tab[i].kind)
        DRV_SOURCE: v = 1'b1;
        DRV_AND:    v = (hi == cnt);
        DRV_OR:     v = (hi != 0);
        DRV_NAND:   v = (hi != cnt);
        DRV_NOR:    v = (hi == 0);
        default:    v = 1'b0;
      endcase
      if (v && drv_tab[i].target < nc) next_lv[drv_tab[i].target] = 1'b1;
    end
    foreach (cond[i]) cond[i] = 1'b0;
    for (int i = 0; i < nr; i++) begin
      hi = high_inputs(rly_tab[i], cnt);
      if (rly_tab[i].kind == REL_POS && rly_tab[i].target < np)
        cond[rly_tab[i].target] = (hi != 0);
      else if (rly_tab[i].kind == REL_NEG && rly_tab[i].target < np)
        cond[rly_tab[i].target] = (hi != cnt);
    end
    foreach (comp_lv[i]) comp_lv[i] = next_lv[i];
    foreach (pix_lv[i]) pix_lv[i] = 1'b0;
    flood_levels();
  endfunction

  function automatic level_result_t apply_item(entry_t e, logic [3:0] op, int slot,
                                               logic lvl);
    level_result_t r;
    r = '0;
    case (op)
      OP_RANGE:  if (slot < NCOMP) begin
        rng_beg[slot] = e.link_a;
        rng_end[slot] = e.link_b;
      end
      OP_ADJ:    if (slot < NADJ) adj[slot] = e.target;
      OP_PIXNB:  if (slot < NPIX) pix_nb[slot] = e;
      OP_DRIVER: if (slot < NDRV) drv_tab[slot] = e;
      OP_RELAY:  if (slot < NRLY) rly_tab[slot] = e;
      OP_WRLVL: begin
        if (e.kind == LVL_COMP && slot < NCOMP) comp_lv[slot] = lvl;
        else if (e.kind == LVL_PIX && slot < NPIX) pix_lv[slot] = lvl;
        else if (e.kind == LVL_COND && slot < NPIX) cond[slot] = lvl;
      end
      OP_STEP: begin
        step_levels();
        r.done = 1'b1;
      end
      OP_SETTLE: begin
        flood_levels();
        r.done = 1'b1;
      end
      OP_READ: begin
        if (e.kind == LVL_COMP && slot < NCOMP) r.rd = comp_lv[slot];
        else if (e.kind == LVL_PIX && slot < NPIX) r.rd = pix_lv[slot];
        else if (e.kind == LVL_COND && slot < NPIX) r.rd = cond[slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    comp_n = '0;
    pix_n = '0;
    drv_n = '0;
    rly_n = '0;
    foreach (comp_lv[i]) begin
      comp_lv[i] = 1'b0;
      next_lv[i] = 1'b0;
    end
    foreach (cond[i]) begin
      cond[i] = 1'b0;
      pix_lv[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    entry_t        e;
    level_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COMP: comp_n = cfg_data;
          REG_PIX:  pix_n = cfg_data;
          REG_DRV:  drv_n = cfg_data;
          default:  rly_n = cfg_data;
        endcase
      end
      if (out_valid) begin
        if (level_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result rd=%0b done=%0b",
                                     out_read_level, out_step_done);
        end else begin
          want = level_q.pop_front();
          if (want.rd !== out_read_level || want.done !== out_step_done) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected rd=%0b done=%0b, got rd=%0b done=%0b",
                       want.rd, want.done, out_read_level, out_step_done);
          end
        end
      end
      if (start && !busy) begin
        e.kind = in_kind;
        e.count = in_input_count;
        e.link_a = in_link_a;
        e.link_b = in_link_b;
        e.link_c = in_link_c;
        e.link_d = in_link_d;
        e.target = in_target;
        level_q.push_back(apply_item(e, in_op, int'(in_slot), in_level));
      end
    end
  end

endmodule

// ----- sim/relay_logic_netlist_step_tb.sv -----
module relay_logic_netlist_step_tb;
  import rlns_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int TBL = 32;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_op;
  logic [11:0] in_slot;
  logic [2:0]  in_kind;
  logic [2:0]  in_input_count;
  logic [11:0] in_link_a;
  logic [11:0] in_link_b;
  logic [9:0]  in_link_c;
  logic [9:0]  in_link_d;
  logic [9:0]  in_target;
  logic        in_level;
  logic        out_valid;
  logic        out_read_level;
  logic        out_step_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  int          pending;
  int          errors;
  int          idle_cycles;
  bit          no_gaps;

  relay_logic_netlist_step u_dut (.*);

  relay_logic_netlist_step_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("relay_logic_netlist_step_tb failed");
      $finish;
    end
  end

  function automatic int pick_link(int bits);
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 63)
                                        : $urandom_range(0, (1 << bits) - 1);
  endfunction

  task automatic send(logic [3:0] op, int slot, int kind, int cnt, int a, int b,
                      int c, int d, int tgt, int lvl);
    if (!no_gaps && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_op <= op;
    in_slot <= 12'(slot);
    in_kind <= 3'(kind);
    in_input_count <= 3'(cnt);
    in_link_a <= 12'(a);
    in_link_b <= 12'(b);
    in_link_c <= 10'(c);
    in_link_d <= 10'(d);
    in_target <= 10'(tgt);
    in_level <= 1'(lvl);
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic load(logic [3:0] op, int slot);
    int beg, fin;
    beg = $urandom_range(0, TBL - 6);
    fin = ($urandom_range(0, 9) == 0) ? $urandom_range(0, beg)
                                      : beg + $urandom_range(0, 5);
    if (fin > 4095) fin = 4095;
    if (op == OP_RANGE)
      send(op, slot, $urandom_range(0, 7), $urandom_range(0, 7), beg, fin,
           $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 1));
    else
      send(op, slot, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                 : $urandom_range(0, 4),
           ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
           pick_link(12), pick_link(12), pick_link(10), pick_link(10), pick_link(10),
           $urandom_range(0, 1));
  endtask

  task automatic random_item();
    int r, slot, kind;
    r = $urandom_range(0, 99);
    slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
    kind = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
    if (r < 45)
      load(4'($urandom_range(OP_RANGE, OP_RELAY)), slot);
    else if (r < 65)
      send(OP_WRLVL, slot, kind, $urandom_range(0, 7), $urandom_range(0, 4095),
           $urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 1023), $urandom_range(0, 1));
    else if (r < 85)
      send(OP_READ, slot, kind, $urandom_range(0, 7), $urandom_range(0, 4095),
           $urandom_range(0, 4095), $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 1023), $urandom_range(0, 1));
    else if (r < 92)
      send(OP_STEP, slot, kind, 0, 0, 0, 0, 0, 0, 0);
    else if (r < 97)
      send(OP_SETTLE, slot, kind, 0, 0, 0, 0, 0, 0, 0);
    else
      send(4'($urandom_range(9, 15)), $urandom_range(0, 4095), $urandom_range(0, 7),
           $urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, 4095),
           $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 1));
  endtask

  task automatic set_counts(int nc, int np, int nd, int nr);
    int vals [4];
    vals = '{nc, np, nd, nr};
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_index <= 2'(i);
      cfg_data <= 11'(vals[i]);
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= n / 3 && i < n / 3 + 40);
      random_item();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = '0;
    in_slot = '0;
    in_kind = '0;
    in_input_count = '0;
    in_link_a = '0;
    in_link_b = '0;
    in_link_c = '0;
    in_link_d = '0;
    in_target = '0;
    in_level = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_READ, 0, LVL_COMP, 0, 0, 0, 0, 0, 0, 0);
    set_counts(24, 16, 20, 20);
    for (int i = 0; i < TBL; i++) load(OP_RANGE, i);
    for (int i = 0; i < TBL; i++) load(OP_ADJ, i);
    for (int i = 0; i < TBL; i++) load(OP_PIXNB, i);
    for (int i = 0; i < TBL; i++) load(OP_DRIVER, i);
    for (int i = 0; i < TBL; i++) load(OP_RELAY, i);

    send(OP_WRLVL, 5, LVL_COMP, 0, 0, 0, 0, 0, 0, 1);
    send(OP_READ, 5, LVL_COMP, 0, 0, 0, 0, 0, 0, 0);
    send(OP_WRLVL, 4095, LVL_PIX, 0, 0, 0, 0, 0, 0, 1);
    send(OP_WRLVL, 3, 3'd7, 0, 0, 0, 0, 0, 0, 1);
    send(OP_READ, 4095, LVL_COND, 0, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 0, 3'd7, 0, 0, 0, 0, 0, 0, 0);
    send(OP_DRIVER, 0, DRV_SOURCE, 0, 0, 0, 0, 0, 3, 0);
    send(OP_DRIVER, 1, DRV_AND, 0, 0, 0, 0, 0, 4, 0);
    send(OP_DRIVER, 2, DRV_NOR, 0, 0, 0, 0, 0, 6, 0);
    send(OP_DRIVER, 3, 3'd6, 2, 3, 4, 0, 0, 7, 0);
    send(OP_DRIVER, 4, DRV_NAND, 7, 3, 4, 1023, 1023, 1023, 0);
    send(OP_RELAY, 0, REL_POS, 1, 3, 0, 0, 0, 2, 0);
    send(OP_RELAY, 1, REL_NEG, 4, 3, 4, 6, 9, 2, 0);
    send(OP_RELAY, 2, 3'd5, 1, 3, 0, 0, 0, 2, 0);
    send(OP_RANGE, 3, 0, 0, 10, 12, 0, 0, 0, 0);
    send(OP_ADJ, 10, 0, 0, 0, 0, 0, 0, 2, 0);
    send(OP_PIXNB, 2, 0, 3, 3, 8, 9, 0, 0, 0);
    send(OP_DRIVER, 4095, DRV_SOURCE, 0, 0, 0, 0, 0, 8, 0);
    send(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 8, LVL_COMP, 0, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 2, LVL_COND, 0, 0, 0, 0, 0, 0, 0);
    send(OP_WRLVL, 2, LVL_PIX, 0, 0, 0, 0, 0, 0, 1);
    send(OP_SETTLE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(4'd15, 4095, 7, 7, 4095, 4095, 1023, 1023, 1023, 1);

    random_phase(90);
    set_counts(TBL, TBL, TBL, TBL);
    random_phase(30);
    set_counts(0, 0, 0, 0);
    random_phase(20);
    set_counts(TBL, TBL, TBL, 1);
    random_phase(25);
    set_counts(28, 24, 20, 20);
    random_phase(100);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("relay_logic_netlist_step_tb passed");
    end else begin
      $display("relay_logic_netlist_step_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rlns_pkg.sv
rtl/rlns_ram.sv
rtl/rlns_ctrl.sv
rtl/rlns_dpath.sv
rtl/relay_logic_netlist_step.sv
sim/relay_logic_netlist_step_checker.sv
sim/relay_logic_netlist_step_tb.sv
